@@ rtl/core/lz11_pkg.sv @@
// Package with shared types and constants for the LZ11 / 0x40 decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lz11_pkg;
  localparam int LenW = 24;
  localparam int WinAw = 12;
  localparam int CfgAw = 1;
  localparam int CfgDw = 24;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLIP  = 2'd1,
    ST_EARLY = 2'd2,
    ST_DIST  = 2'd3
  } status_t;

  localparam logic [CfgAw-1:0] REG_FORMAT = 1'd0;
  localparam logic [CfgAw-1:0] REG_RAWLEN = 1'd1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stream_done;
    logic [1:0] status;
  } out_item_t;

  // History memory request: reads from the parser, writes from the second stage.
  typedef struct packed {
    logic             we;
    logic [WinAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [WinAw-1:0] raddr;
  } hist_req_t;
endpackage
`default_nettype wire

@@ rtl/core/lz11_if.sv @@
// Valid/ready stream interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface lz11_in_if;
  logic                valid;
  logic                ready;
  lz11_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lz11_out_if;
  logic                valid;
  logic                ready;
  lz11_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lz11_hist.sv @@
// 4096-byte history memory with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lz11_hist (
  input  wire logic                clk,
  input  wire lz11_pkg::hist_req_t req,
  output logic [7:0]               rdata
);
  import lz11_pkg::*;
  logic [7:0] mem [0:(1<<WinAw)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/lz11_lz40_decompressor.sv @@
// Top level of the LZ11 / 0x40 LZ77 decompressor.
`timescale 1ns / 1ps
`default_nettype none
// The decompressor takes one compressed byte (command 0), one copy step
// (command 1) or a stream start (command 2) per input transfer and gives at
// most one result transfer per item. Items are taken one per cycle unless the
// input stalls: the parser updates its stream state in the cycle of acceptance,
// and a copy step issues its history read then; the byte read comes back in
// the next cycle into the second stage, which queues the result and writes
// every output byte, literal or copied, into history. A copy that reads a byte
// written by the immediately preceding item takes it from a forwarding register
// instead of the memory. Results pass through a two-entry output buffer; the
// input stalls when the results in it and in stage 2 number three, or two
// while the result side is not taking one. The history memory has no reset
// and no clearing pass; the distance check keeps reads inside written bytes.
module lz11_lz40_decompressor (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lz11_in_if.sink                           in_ch,
  lz11_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [lz11_pkg::CfgAw-1:0]   cfg_index,
  input  wire logic [lz11_pkg::CfgDw-1:0]   cfg_data
);
  import lz11_pkg::*;

  // Configuration registers.
  logic            fmt_r;
  logic [LenW-1:0] rawlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= 1'b0;
      rawlen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT: fmt_r    <= cfg_data[0];
        REG_RAWLEN: rawlen_r <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Stream state.
  logic [LenW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [3:0]      fidx_r, fidx_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [2:0]      need_r, need_nxt;
  logic [31:0]     tok_r, tok_nxt;
  logic [16:0]     crem_r, crem_nxt;
  logic [12:0]     cdist_r, cdist_nxt;
  logic            iend_r, iend_nxt;
  logic [1:0]      sticky_r, sticky_nxt;
  logic            done_r, done_nxt;

  // Second stage: result under construction.
  logic            s2_v_r;
  logic            s2_rd_r;     // byte comes from history
  logic            s2_fwd_r;    // byte comes from forwarding register
  logic [WinAw-1:0] s2_addr_r;
  out_item_t       s2_item_r;
  logic [7:0]      last_b_r;    // last byte written to history
  logic [7:0]      hist_q;

  // Output buffer, two entries.
  out_item_t       ob_r [0:1];
  logic            ob_wp_r, ob_rp_r;
  logic [1:0]      ob_cnt_r;

  logic acc;
  logic room;
  // Room is counted so that an item in stage 2 always finds a slot.
  assign room = (ob_cnt_r + {1'b0, s2_v_r}) < 2'd2 ||
                (out_ch.ready && ob_cnt_r != 2'd0 &&
                 (ob_cnt_r + {1'b0, s2_v_r}) < 2'd3);
  assign in_ch.ready = room;
  assign acc = in_ch.valid && in_ch.ready;

  in_item_t it;
  assign it = in_ch.data;

  logic       emit, e_has, e_fin, e_rd, e_fwd;
  logic [7:0] e_byte;
  hist_req_t  hreq;

  logic [2:0]  bneed;
  logic [31:0] tv;
  logic [16:0] len;
  logic [12:0] rdist;
  logic [7:0]  rb0, rb1;
  logic [LenW:0] endpos;
  logic [LenW-1:0] cnt1;
  logic [LenW-1:0] rdpos;
  logic [1:0]  st;

  always_comb begin
    cnt_nxt = cnt_r; flags_nxt = flags_r; fidx_nxt = fidx_r;
    phase_nxt = phase_r; need_nxt = need_r; tok_nxt = tok_r;
    crem_nxt = crem_r; cdist_nxt = cdist_r; iend_nxt = iend_r;
    sticky_nxt = sticky_r; done_nxt = done_r;
    emit = 1'b0; e_has = 1'b0; e_fin = 1'b0; e_rd = 1'b0; e_fwd = 1'b0;
    e_byte = 8'd0;
    hreq = '0;
    st = sticky_r;
    cnt1 = cnt_r + 1'b1;
    rdpos = cnt_r - LenW'(cdist_r);
    bneed = 3'd2; tv = '0; len = '0; rdist = '0; rb0 = '0; rb1 = '0;
    endpos = '0;
    if (acc) begin
      if (it.command == CMD_START) begin
        cnt_nxt = '0; flags_nxt = '0; fidx_nxt = '0; phase_nxt = '0;
        need_nxt = '0; tok_nxt = '0; crem_nxt = '0; cdist_nxt = '0;
        iend_nxt = 1'b0; sticky_nxt = ST_OK; done_nxt = 1'b0;
      end else if (it.command == CMD_NONE || done_r) begin
      end else if (cnt_r >= rawlen_r) begin
        done_nxt = 1'b1; emit = 1'b1; e_fin = 1'b1;
      end else if (it.command == CMD_STEP) begin
        if (crem_r != 17'd0) begin
          emit = 1'b1; e_has = 1'b1;
          if (cdist_r == 13'd0 || LenW'(cdist_r) > cnt_r) begin
            if (st == ST_OK) st = ST_DIST;
            e_byte = 8'd0;
          end else if (cdist_r == 13'd1) begin
            e_fwd = 1'b1;
          end else begin
            e_rd = 1'b1;
            hreq.re = 1'b1;
            hreq.raddr = rdpos[WinAw-1:0];
          end
          cnt_nxt = cnt1;
          crem_nxt = crem_r - 1'b1;
          if (cnt1 >= rawlen_r) done_nxt = 1'b1;
          else if (crem_r == 17'd1 && iend_r) begin
            if (st == ST_OK) st = ST_EARLY;
            done_nxt = 1'b1;
          end
          e_fin = done_nxt;
          sticky_nxt = st;
        end
      end else if (crem_r != 17'd0) begin
      end else if (fidx_r == 4'd0) begin
        flags_nxt = fmt_r ? (8'd0 - it.in_byte) : it.in_byte;
        fidx_nxt = 4'd8;
        if (it.in_last) begin
          if (st == ST_OK) sticky_nxt = ST_EARLY;
          done_nxt = 1'b1; emit = 1'b1; e_fin = 1'b1;
        end
      end else if (phase_r == 3'd0 && !flags_r[7]) begin
        emit = 1'b1; e_has = 1'b1; e_byte = it.in_byte;
        cnt_nxt = cnt1;
        flags_nxt = {flags_r[6:0], 1'b0};
        fidx_nxt = fidx_r - 1'b1;
        if (cnt1 >= rawlen_r) done_nxt = 1'b1;
        else if (it.in_last) begin
          if (st == ST_OK) sticky_nxt = ST_EARLY;
          done_nxt = 1'b1;
        end
        e_fin = done_nxt;
      end else begin
        if (phase_r == 3'd0) begin
          unique case (fmt_r ? it.in_byte[3:0] : it.in_byte[7:4])
            4'd0:    bneed = 3'd3;
            4'd1:    bneed = 3'd4;
            default: bneed = 3'd2;
          endcase
          need_nxt = bneed;
          tv = {24'd0, it.in_byte};
        end else begin
          bneed = need_r;
          tv = {tok_r[23:0], it.in_byte};
        end
        tok_nxt = tv;
        phase_nxt = phase_r + 1'b1;
        if ((phase_r + 1'b1) < bneed) begin
          if (it.in_last) begin
            if (st == ST_OK) sticky_nxt = ST_EARLY;
            done_nxt = 1'b1; emit = 1'b1; e_fin = 1'b1;
          end
        end else begin
          if (!fmt_r) begin
            unique case (bneed)
              3'd2:    len = 17'(tv[15:12]) + 17'd1;
              3'd3:    len = 17'(tv[19:12]) + 17'h11;
              default: len = 17'(tv[27:12]) + 17'h111;
            endcase
            rdist = 13'(tv[11:0]) + 13'd1;
          end else begin
            unique case (bneed)
              3'd2: begin rb0 = tv[15:8];  rb1 = tv[7:0];  end
              3'd3: begin rb0 = tv[23:16]; rb1 = tv[15:8]; end
              default: begin rb0 = tv[31:24]; rb1 = tv[23:16]; end
            endcase
            rdist = 13'({rb1, rb0} >> 4);
            unique case (bneed)
              3'd2:    len = 17'(rb0[3:0]);
              3'd3:    len = 17'(tv[7:0]) + 17'h10;
              default: len = 17'({tv[7:0], tv[15:8]}) + 17'h110;
            endcase
          end
          endpos = {1'b0, cnt_r} + (LenW+1)'(len);
          if (endpos > {1'b0, rawlen_r}) begin
            len = 17'(rawlen_r - cnt_r);
            if (st == ST_OK) sticky_nxt = ST_CLIP;
          end
          crem_nxt = len;
          cdist_nxt = rdist;
          flags_nxt = {flags_r[6:0], 1'b0};
          fidx_nxt = fidx_r - 1'b1;
          phase_nxt = 3'd0;
          iend_nxt = it.in_last;
        end
      end
    end
    // Every output byte, literal or copied, is written into history from
    // stage 2, so there is a single write per cycle.
    if (s2_v_r && s2_item_r.has_byte) begin
      hreq.we = 1'b1;
      hreq.waddr = s2_addr_r;
      hreq.wdata = s2_rd_r ? hist_q : (s2_fwd_r ? last_b_r : s2_item_r.out_byte);
    end
  end

  lz11_hist u_hist (.clk(clk), .req(hreq), .rdata(hist_q));

  // Stage 2: the byte is completed here and written into history.
  logic s2_copy_r;
  out_item_t s2_final;
  always_comb begin
    s2_final = s2_item_r;
    if (s2_rd_r) s2_final.out_byte = hist_q;
    else if (s2_fwd_r) s2_final.out_byte = last_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; flags_r <= '0; fidx_r <= '0; phase_r <= '0; need_r <= '0;
      tok_r <= '0; crem_r <= '0; cdist_r <= '0; iend_r <= 1'b0;
      sticky_r <= ST_OK; done_r <= 1'b0; s2_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; flags_r <= flags_nxt; fidx_r <= fidx_nxt;
      phase_r <= phase_nxt; need_r <= need_nxt; tok_r <= tok_nxt;
      crem_r <= crem_nxt; cdist_r <= cdist_nxt; iend_r <= iend_nxt;
      sticky_r <= sticky_nxt; done_r <= done_nxt; s2_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_rd_r   <= e_rd;
    s2_fwd_r  <= e_fwd;
    s2_copy_r <= (it.command == CMD_STEP);
    s2_addr_r <= cnt_r[WinAw-1:0];
    s2_item_r <= '{out_byte: e_byte, has_byte: e_has, stream_done: e_fin,
                   status: sticky_nxt};
    // A literal accepted now is newer than the byte in stage 2.
    if (emit && e_has && it.command != CMD_STEP) last_b_r <= e_byte;
    else if (s2_v_r && s2_final.has_byte) last_b_r <= s2_final.out_byte;
  end

  // Stage 2 holds a copied byte that must be written back.
  logic s2_wb;
  assign s2_wb = s2_v_r && s2_copy_r && s2_item_r.has_byte;

  // Output buffer.
  logic push, pop;
  assign push = s2_v_r;
  assign pop  = out_ch.valid && out_ch.ready;
  assign out_ch.valid = ob_cnt_r != 2'd0;
  assign out_ch.data  = ob_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r <= 1'b0; ob_rp_r <= 1'b0; ob_cnt_r <= '0;
    end else begin
      if (push) ob_wp_r <= ~ob_wp_r;
      if (pop)  ob_rp_r <= ~ob_rp_r;
      ob_cnt_r <= ob_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (push) ob_r[ob_wp_r] <= s2_final;
  end

  // The buffer never overflows.
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= 2'd2) else $error("output buffer overflow");
  // No push into a full buffer without a pop.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && ob_cnt_r == 2'd2) |-> pop) else $error("push into full buffer");
  // A history read always has a result in stage 2 the next cycle.
  a_rd_s2: assert property (@(posedge clk) disable iff (!rst_n)
    hreq.re |=> (s2_v_r && s2_rd_r && s2_wb)) else $error("lost history read");
endmodule
`default_nettype wire

@@ tb/sv/tb_lz11_lz40_decompressor.sv @@
// Self-checking testbench for the LZ11 / 0x40 decompressor.
`timescale 1ns / 1ps
import lz11_pkg::*;

// The scoreboard runs its own copy of the decoder. Each accepted input transfer
// updates it and may queue one expected result. Each result transfer is then
// compared field by field with the oldest queued result.
class lz_scoreboard;
  bit          fmt;
  bit [23:0]   raw_len;
  logic [7:0]  hist [4096];
  bit [23:0]   out_count;
  bit [7:0]    flag_bits;
  int          flag_idx;
  int          phase;
  int          need;
  bit [31:0]   tok;
  int unsigned copy_rem;
  int unsigned copy_dist;
  bit          input_ended;
  bit          done;
  status_t     sticky;
  out_item_t   exp_q[$];
  int          errors;
  int          checked;

  function void clear_stream();
    out_count = 0; flag_bits = 0; flag_idx = 0; phase = 0; need = 0; tok = 0;
    copy_rem = 0; copy_dist = 0; input_ended = 0; done = 0; sticky = ST_OK;
  endfunction

  function void set_status(status_t s);
    if (sticky == ST_OK) sticky = s;
  endfunction

  function void push(bit [7:0] b, bit has, bit fin);
    out_item_t r;
    r.out_byte = b; r.has_byte = has; r.stream_done = fin; r.status = sticky;
    exp_q.push_back(r);
  endfunction

  function void put(bit [7:0] b);
    hist[out_count[11:0]] = b;
    out_count = out_count + 24'd1;
  endfunction

  // Turns the collected reference bytes into a pending copy.
  function void decode_ref();
    int unsigned len, b0, b1;
    if (!fmt) begin
      if (need == 2) len = ((tok >> 12) & 'hF) + 1;
      else if (need == 3) len = ((tok >> 12) & 'hFF) + 'h11;
      else len = ((tok >> 12) & 'hFFFF) + 'h111;
      copy_dist = (tok & 'hFFF) + 1;
    end else begin
      b0 = (tok >> (8 * (need - 1))) & 'hFF;
      b1 = (tok >> (8 * (need - 2))) & 'hFF;
      copy_dist = (b0 | (b1 << 8)) >> 4;
      if (need == 2) len = b0 & 'hF;
      else if (need == 3) len = (tok & 'hFF) + 'h10;
      else len = (((tok & 'hFF) << 8) | ((tok >> 8) & 'hFF)) + 'h110;
    end
    if (longint'(out_count) + len > raw_len) begin
      len = (raw_len > out_count) ? 32'(raw_len - out_count) : 0;
      set_status(ST_CLIP);
    end
    copy_rem = len;
  endfunction

  function void note_input(in_item_t it);
    bit [7:0] b, v;
    int unsigned t;
    b = it.in_byte;
    if (it.command == CMD_START) begin
      clear_stream();
      return;
    end
    if (it.command == CMD_NONE || done) return;
    if (out_count >= raw_len) begin
      done = 1; push(0, 0, 1); return;
    end
    if (it.command == CMD_STEP) begin
      if (copy_rem == 0) return;
      v = 0;
      if (copy_dist == 0 || copy_dist > out_count) set_status(ST_DIST);
      else v = hist[(out_count - copy_dist) & 'hFFF];
      put(v);
      copy_rem--;
      if (out_count >= raw_len) done = 1;
      else if (copy_rem == 0 && input_ended) begin
        set_status(ST_EARLY); done = 1;
      end
      push(v, 1, done);
      return;
    end
    if (copy_rem != 0) return;
    if (flag_idx == 0) begin
      flag_bits = fmt ? 8'(-b) : b;
      flag_idx = 8;
      if (it.in_last) begin
        set_status(ST_EARLY); done = 1; push(0, 0, 1);
      end
      return;
    end
    if (phase == 0 && !flag_bits[7]) begin
      put(b);
      flag_bits = flag_bits << 1;
      flag_idx--;
      if (out_count >= raw_len) done = 1;
      else if (it.in_last) begin
        set_status(ST_EARLY); done = 1;
      end
      push(b, 1, done);
      return;
    end
    if (phase == 0) begin
      t = fmt ? b[3:0] : b[7:4];
      need = (t == 0) ? 3 : (t == 1) ? 4 : 2;
      tok = 0;
    end
    tok = (tok << 8) | b;
    phase++;
    if (phase < need) begin
      if (it.in_last) begin
        set_status(ST_EARLY); done = 1; push(0, 0, 1);
      end
      return;
    end
    decode_ref();
    flag_bits = flag_bits << 1;
    flag_idx--;
    phase = 0;
    input_ended = it.in_last;
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (exp_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    want = exp_q.pop_front();
    checked++;
    if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
        got.stream_done !== want.stream_done || got.status !== want.status) begin
      errors++;
      if (errors <= 10) $display("ERROR: result mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_lz11_lz40_decompressor;
  logic              clk = 0;
  logic              rst_n;
  logic              cfg_we;
  logic [CfgAw-1:0]  cfg_index;
  logic [CfgDw-1:0]  cfg_data;

  lz11_in_if  in_ch ();
  lz11_out_if out_ch ();

  lz11_lz40_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lz_scoreboard sb = new();

  // Idle percentages for each side, and the long receiver hold-off request.
  int snd_pct;
  int rcv_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int items_sent;
  int streams;

  always #2 clk = ~clk;

  // The receiver owns out_ch.ready. A hold-off request from the main process
  // is picked up here and counted down in cycles, so that the output buffer
  // fills and the block must stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 80;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_pct);
    end
  end

  // Every result transfer is checked against the scoreboard. The values seen
  // here are those from before the edge, so the check does not race the block.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // Offers one item and waits for its transfer. The valid stays high on return
  // so that back-to-back items need no second assignment in the same step.
  task automatic send_item(cmd_t cmd, bit [7:0] b, bit last);
    in_item_t it;
    it.command = cmd; it.in_byte = b; it.in_last = last;
    if ($urandom_range(99) < snd_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_input(it);
    items_sent++;
  endtask

  // Waits until every expected result has come, then lets the pipeline settle
  // in case the last items were ones that give no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.exp_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(bit fmt, bit [23:0] raw);
    drain();
    cfg_we <= 1'b1; cfg_index <= REG_FORMAT; cfg_data <= CfgDw'(fmt);
    @(posedge clk);
    cfg_index <= REG_RAWLEN; cfg_data <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.fmt = fmt;
    sb.raw_len = raw;
  endtask

  // Sends one back-reference token whose distance mostly points into the
  // bytes already written and whose length is mostly short.
  task automatic send_ref(int last_pct);
    bit [7:0]  bytes [4];
    int        n, cut;
    bit [11:0] d;
    bit [15:0] ln;
    int unsigned lim;
    n = $urandom_range(2, 4);
    lim = (sb.out_count > 4095) ? 4095 : sb.out_count;
    if (lim == 0 || $urandom_range(99) < 8) d = 12'($urandom);
    else d = 12'(sb.fmt ? $urandom_range(1, lim) : $urandom_range(0, lim - 1));
    ln = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 30));
    if (!sb.fmt) begin
      case (n)
        2: begin bytes[0] = {4'($urandom_range(2, 15)), d[11:8]}; bytes[1] = d[7:0]; end
        3: begin
          bytes[0] = {4'h0, ln[7:4]}; bytes[1] = {ln[3:0], d[11:8]}; bytes[2] = d[7:0];
        end
        default: begin
          bytes[0] = {4'h1, ln[15:12]}; bytes[1] = ln[11:4];
          bytes[2] = {ln[3:0], d[11:8]}; bytes[3] = d[7:0];
        end
      endcase
    end else begin
      bytes[1] = d[11:4];
      case (n)
        2: bytes[0] = {d[3:0], 4'($urandom_range(2, 15))};
        3: begin bytes[0] = {d[3:0], 4'h0}; bytes[2] = ln[7:0]; end
        default: begin
          bytes[0] = {d[3:0], 4'h1}; bytes[2] = ln[7:0]; bytes[3] = ln[15:8];
        end
      endcase
    end
    // Now and then the input ends inside or right after the token.
    cut = ($urandom_range(99) < last_pct) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < n; i++) send_item(CMD_BYTE, bytes[i], i == cut);
  endtask

  // One stream: a start, then mostly well-formed tokens with copy steps as
  // needed, salted with stray items, until it is done or the budget runs out.
  task automatic run_stream(int budget, int last_pct);
    int first;
    streams++;
    first = items_sent;
    send_item(CMD_START, 8'($urandom), 1'($urandom));
    while (!sb.done && items_sent - first < budget) begin
      if ($urandom_range(99) < 4)
        send_item(cmd_t'($urandom_range(0, 3) == 2 ? 3 : $urandom_range(0, 3)),
                  8'($urandom), $urandom_range(99) < 10);
      else if (sb.copy_rem > 0)
        send_item(CMD_STEP, 8'($urandom), 1'($urandom));
      else if (sb.flag_idx == 0)
        send_item(CMD_BYTE, 8'($urandom), $urandom_range(99) < last_pct / 4);
      else if (sb.phase == 0 && !sb.flag_bits[7])
        send_item(CMD_BYTE, 8'($urandom), $urandom_range(99) < last_pct);
      else
        send_ref(last_pct);
    end
    // Items after the end of a stream must be ignored.
    if (sb.done && $urandom_range(99) < 30) begin
      send_item(CMD_BYTE, 8'($urandom), 1'b0);
      send_item(CMD_STEP, 8'($urandom), 1'b1);
    end
  endtask

  task automatic random_phase(int s_pct, int r_pct, int n_items, bit pressure);
    int stop;
    bit [23:0] raw;
    snd_pct = s_pct;
    rcv_pct = r_pct;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      case ($urandom_range(19))
        0:       raw = 24'd0;
        1:       raw = 24'hFFFFFF;
        2:       raw = 24'($urandom_range(150, 5000));
        default: raw = 24'($urandom_range(1, 150));
      endcase
      configure(1'($urandom), raw);
      if (pressure && streams % 6 == 3) hold_req++;
      run_stream($urandom_range(20, 160), $urandom_range(0, 1) ? 0 : 4);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    snd_pct = 0;
    rcv_pct = 0;
    hold_req = 0;
    items_sent = 0;
    streams = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed streams: zero length, plain runs in both formats, an early end,
    // and the largest length.
    configure(1'b0, 24'd0);
    run_stream(3, 0);
    configure(1'b0, 24'd20);
    run_stream(6, 0);
    configure(1'b1, 24'd20);
    run_stream(6, 0);
    configure(1'b0, 24'd50);
    run_stream(5, 60);
    configure(1'b1, 24'hFFFFFF);
    run_stream(5, 0);

    random_phase(26, 68, 420, 1'b1);
    random_phase(68, 26, 420, 1'b1);
    random_phase(0, 0, 420, 1'b0);

    drain();
    $display("Covered %0d streams and %0d input items in both token formats;",
             streams, items_sent);
    $display("%0d results were compared with the predicted output.", sb.checked);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.exp_q.size());
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Timeout: the run did not complete");
    $display("FAILURE");
    $finish;
  end
endmodule

@@ lz11_lz40_decompressor.f @@
rtl/core/lz11_pkg.sv
rtl/core/lz11_if.sv
rtl/core/lz11_hist.sv
rtl/core/lz11_lz40_decompressor.sv
tb/sv/tb_lz11_lz40_decompressor.sv
